### hw/rtl/cgrb_pkg.sv
// Shared types, constants and helper functions of the clipped glyph row blitter.
`timescale 1ns / 1ps

package cgrb_pkg;

    localparam int MAX_GLYPHS  = 256;
    localparam int MAX_GLYPH_H = 32;
    localparam int MAX_GLYPH_W = 16;

    localparam int GLYPH_IDX_W = $clog2(MAX_GLYPHS);
    localparam int ROW_IDX_W   = $clog2(MAX_GLYPH_H);
    localparam int MEM_AW      = GLYPH_IDX_W + ROW_IDX_W;
    localparam int MEM_DEPTH   = MAX_GLYPHS * MAX_GLYPH_H;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 88;

    localparam logic [12:0] SURF_MAX = 13'd4096;
    localparam logic [4:0]  WD_CAP   = 5'd16;
    localparam logic [5:0]  HT_CAP   = 6'd32;
    localparam logic [31:0] COLOR_MASK = 32'hFFFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SURF_WIDTH   = 3'd0,
        CFG_SURF_HEIGHT  = 3'd1,
        CFG_GLYPH_WIDTH  = 3'd2,
        CFG_GLYPH_HEIGHT = 3'd3,
        CFG_FIRST_CODE   = 3'd4,
        CFG_GLYPH_COUNT  = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_DRAW = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLIP,
        S_PLAN,
        S_ROWS
    } t_state;

    typedef struct packed {
        logic [12:0] surf_width;
        logic [12:0] surf_height;
        logic [4:0]  glyph_width;
        logic [5:0]  glyph_height;
        logic [7:0]  first_code;
        logic [8:0]  glyph_count;
    } t_cfg;

    // Clip results handed from the geometry unit to the row sequencer.
    typedef struct packed {
        logic        rowless;
        logic [4:0]  adv;
        logic [11:0] row0;
        logic [11:0] col;
        logic [4:0]  nc;
        logic [3:0]  xb;
        logic [5:0]  nl;
        logic [4:0]  yb;
        logic [GLYPH_IDX_W-1:0] k;
        logic [15:0] cmask;
        logic [31:0] color;
        logic        opq;
    } t_geom;

    function automatic logic [12:0] sat_surf(input logic [12:0] v);
        return (v > SURF_MAX) ? SURF_MAX : v;
    endfunction

    function automatic logic [4:0] sat_wd(input logic [4:0] v);
        return (v > WD_CAP) ? WD_CAP : v;
    endfunction

    function automatic logic [5:0] sat_ht(input logic [5:0] v);
        return (v > HT_CAP) ? HT_CAP : v;
    endfunction

endpackage

### hw/rtl/cgrb_clip.sv
// Two-stage clip unit: glyph lookup index and visible window of one draw beat.
`timescale 1ns / 1ps

module cgrb_clip (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  cgrb_pkg::t_cfg       i_cfg,
    input  logic [12:0]          i_pos_x,
    input  logic [12:0]          i_pos_y,
    input  logic [7:0]           i_char_code,
    input  logic [31:0]          i_color,
    input  logic                 i_opaque,
    output logic                 o_geom_vld,
    output cgrb_pkg::t_geom      o_geom
);

    logic [12:0] surf_w;
    logic [12:0] surf_h;
    logic [4:0]  wd;
    logic [5:0]  ht;

    // Stage one
    logic [7:0]  k;
    logic        absent;
    logic [11:0] xs;
    logic        right_out;
    logic [12:0] xb;
    logic [14:0] ys;

    logic        r_s1_vld;
    logic        r_s2_vld;
    logic        r_absent;
    logic        r_right_out;
    logic [7:0]  r_k;
    logic [11:0] r_xs;
    logic [12:0] r_xb;
    logic [14:0] r_ys;
    logic [31:0] r_color;
    logic        r_opq;

    // Stage two
    logic        below;
    logic        left_out;
    logic [14:0] yb_full;
    logic        above;
    logic [12:0] ys_c;
    logic [12:0] cols_surf;
    logic [4:0]  cols_glyph;
    logic [4:0]  nc;
    logic [12:0] rows_surf;
    logic [5:0]  rows_glyph;
    logic [5:0]  nl;
    logic [16:0] mask_wide;
    logic        rowless;
    logic [4:0]  adv;

    t_geom_assign: assert final (1'b1);

    assign surf_w = cgrb_pkg::sat_surf(i_cfg.surf_width);
    assign surf_h = cgrb_pkg::sat_surf(i_cfg.surf_height);
    assign wd     = cgrb_pkg::sat_wd(i_cfg.glyph_width);
    assign ht     = cgrb_pkg::sat_ht(i_cfg.glyph_height);

    always_comb begin
        k         = (i_char_code == 8'd0) ? 8'd0 : (i_char_code - i_cfg.first_code);
        absent    = ({1'b0, k} >= i_cfg.glyph_count);
        xs        = i_pos_x[12] ? 12'd0 : i_pos_x[11:0];
        right_out = ({1'b0, xs} >= surf_w);
        xb        = i_pos_x[12] ? (13'd0 - i_pos_x) : 13'd0;
        ys        = {2'b00, surf_h} - {{2{i_pos_y[12]}}, i_pos_y} - {9'd0, ht};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_start;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_absent    <= absent;
            r_right_out <= right_out;
            r_k         <= k;
            r_xs        <= xs;
            r_xb        <= xb;
            r_ys        <= ys;
            r_color     <= i_color & cgrb_pkg::COLOR_MASK;
            r_opq       <= i_opaque;
        end
    end

    always_comb begin
        below      = ($signed(r_ys) >= $signed({2'b00, surf_h}));
        left_out   = (r_xb >= {8'd0, wd});
        yb_full    = r_ys[14] ? (15'd0 - r_ys) : 15'd0;
        above      = (yb_full >= {9'd0, ht});
        ys_c       = r_ys[14] ? 13'd0 : r_ys[12:0];
        cols_surf  = surf_w - {1'b0, r_xs};
        cols_glyph = wd - r_xb[4:0];
        nc         = (cols_surf < {8'd0, cols_glyph}) ? cols_surf[4:0] : cols_glyph;
        rows_surf  = surf_h - ys_c;
        rows_glyph = ht - yb_full[5:0];
        nl         = (rows_surf < {7'd0, rows_glyph}) ? rows_surf[5:0] : rows_glyph;
        mask_wide  = (17'd1 << nc) - 17'd1;

        // The first clip test that fires decides the advance of a rowless beat.
        rowless = 1'b1;
        adv     = 5'd0;
        priority if (r_absent) begin
            adv = 5'd0;
        end else if (r_right_out) begin
            adv = wd;
        end else if (below) begin
            adv = 5'd0;
        end else if (left_out) begin
            adv = wd;
        end else if (above) begin
            adv = 5'd0;
        end else if (nl == 6'd0) begin
            adv = nc;
        end else begin
            rowless = 1'b0;
            adv     = nc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            o_geom.rowless <= rowless;
            o_geom.adv     <= adv;
            o_geom.row0    <= ys_c[11:0];
            o_geom.col     <= r_xs;
            o_geom.nc      <= nc;
            o_geom.xb      <= r_xb[3:0];
            o_geom.nl      <= nl;
            o_geom.yb      <= yb_full[4:0];
            o_geom.k       <= r_k;
            o_geom.cmask   <= mask_wide[15:0];
            o_geom.color   <= r_color;
            o_geom.opq     <= r_opq;
        end
    end

    assign o_geom_vld = r_s2_vld;

endmodule

### hw/rtl/clipped_glyph_row_blitter.sv
// Top level of the clipped glyph row blitter: glyph memory, row sequencer and output register.
`timescale 1ns / 1ps

// Usage: input beats arrive on the s_axis group. tuser selects the kind: a load beat writes
// one 16-bit glyph row into the glyph memory, a draw beat renders one character. A draw
// yields one m_axis beat per visible glyph row, lowest surface row first, with tuser high;
// a draw that clips out early yields a single beat with tuser low. tlast marks the final
// beat of every draw; loads produce no output.
// Timing: a load beat is written while the block stays idle. A draw passes through the clip
// unit and the plan step, then takes one row per cycle while the output register can take
// it, paced by the single read port of the glyph memory (read data registered, in the cycle
// after the address); no new input beat is accepted until the draw is done. Configuration
// is written through i_cfg_we/i_cfg_idx/i_cfg_data, by the user only while the block is idle;
// the block itself does not enforce this. Reset restores the register defaults and clears all
// control state; the glyph memory is not cleared and must be loaded before a glyph is drawn.
// A stalled receiver holds the output beat in its register; the row sequencer issues no
// further read while one is in flight until the output register can take the next row.

module clipped_glyph_row_blitter (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [cgrb_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [cgrb_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // glyph_index[7:0], glyph_row[12:8], row_bits[28:13], pos_x[41:29], pos_y[54:42],
    // char_code[62:55], color[94:63], opaque[95]
    input  logic [cgrb_pkg::S_TDATA_W-1:0]        s_axis_tdata,
    // kind[0]
    input  logic                                  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // surf_row[11:0], surf_col[23:12], pixel_count[28:24], fg_bits[44:29],
    // color_out[76:45], opaque_out[77], advance[82:78], zero padding[87:83]
    output logic [cgrb_pkg::M_TDATA_W-1:0]        m_axis_tdata,
    // row_valid[0]
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast
);

    cgrb_pkg::t_cfg   r_cfg;
    cgrb_pkg::t_state r_state;
    cgrb_pkg::t_state n_state;
    cgrb_pkg::t_geom  geom;
    logic             geom_vld;

    logic [7:0]  in_glyph_index;
    logic [4:0]  in_glyph_row;
    logic [15:0] in_row_bits;
    logic [12:0] in_pos_x;
    logic [12:0] in_pos_y;
    logic [7:0]  in_char_code;
    logic [31:0] in_color;
    logic        in_opaque;

    logic s_accept;
    logic draw_start;
    logic wr_en;
    logic rd_en;
    logic out_free;
    logic load_row;
    logic load_rowless;
    logic iss_done;

    logic [15:0] r_mem [cgrb_pkg::MEM_DEPTH];
    logic [15:0] r_rdata;
    logic [cgrb_pkg::MEM_AW-1:0] waddr;
    logic [cgrb_pkg::MEM_AW-1:0] raddr;
    logic [4:0]  grow;

    logic [5:0]  r_iss;
    logic [5:0]  n_iss;
    logic [5:0]  iss_next;
    logic        r_rd_vld;
    logic        n_rd_vld;
    logic [11:0] r_rd_row;
    logic        r_rd_last;

    logic        r_m_valid;
    logic        n_m_valid;
    logic        r_m_rowv;
    logic        r_m_last;
    logic [11:0] r_m_row;
    logic [11:0] r_m_col;
    logic [4:0]  r_m_cnt;
    logic [15:0] r_m_fg;
    logic [31:0] r_m_color;
    logic        r_m_opq;
    logic [4:0]  r_m_adv;

    assign in_glyph_index = s_axis_tdata[7:0];
    assign in_glyph_row   = s_axis_tdata[12:8];
    assign in_row_bits    = s_axis_tdata[28:13];
    assign in_pos_x       = s_axis_tdata[41:29];
    assign in_pos_y       = s_axis_tdata[54:42];
    assign in_char_code   = s_axis_tdata[62:55];
    assign in_color       = s_axis_tdata[94:63];
    assign in_opaque      = s_axis_tdata[95];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.surf_width   <= 13'd640;
            r_cfg.surf_height  <= 13'd480;
            r_cfg.glyph_width  <= 5'd9;
            r_cfg.glyph_height <= 6'd15;
            r_cfg.first_code   <= 8'd32;
            r_cfg.glyph_count  <= 9'd115;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cgrb_pkg::CFG_SURF_WIDTH:   r_cfg.surf_width   <= i_cfg_data;
                cgrb_pkg::CFG_SURF_HEIGHT:  r_cfg.surf_height  <= i_cfg_data;
                cgrb_pkg::CFG_GLYPH_WIDTH:  r_cfg.glyph_width  <= i_cfg_data[4:0];
                cgrb_pkg::CFG_GLYPH_HEIGHT: r_cfg.glyph_height <= i_cfg_data[5:0];
                cgrb_pkg::CFG_FIRST_CODE:   r_cfg.first_code   <= i_cfg_data[7:0];
                cgrb_pkg::CFG_GLYPH_COUNT:  r_cfg.glyph_count  <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    cgrb_clip u_clip (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (draw_start),
        .i_cfg       (r_cfg),
        .i_pos_x     (in_pos_x),
        .i_pos_y     (in_pos_y),
        .i_char_code (in_char_code),
        .i_color     (in_color),
        .i_opaque    (in_opaque),
        .o_geom_vld  (geom_vld),
        .o_geom      (geom)
    );

    assign out_free = !r_m_valid || m_axis_tready;
    assign iss_done = (r_iss == geom.nl);
    assign iss_next = r_iss + 6'd1;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cgrb_pkg::S_IDLE: begin
                if (s_axis_tvalid && s_axis_tuser == cgrb_pkg::KIND_DRAW) begin
                    n_state = cgrb_pkg::S_CLIP;
                end
            end
            cgrb_pkg::S_CLIP: begin
                if (geom_vld) begin
                    n_state = cgrb_pkg::S_PLAN;
                end
            end
            cgrb_pkg::S_PLAN: begin
                if (!geom.rowless) begin
                    n_state = cgrb_pkg::S_ROWS;
                end else if (out_free) begin
                    n_state = cgrb_pkg::S_IDLE;
                end
            end
            cgrb_pkg::S_ROWS: begin
                if (iss_done && (!r_rd_vld || out_free)) begin
                    n_state = cgrb_pkg::S_IDLE;
                end
            end
            default: n_state = cgrb_pkg::S_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        s_axis_tready = 1'b0;
        rd_en         = 1'b0;
        load_row      = 1'b0;
        load_rowless  = 1'b0;
        unique case (r_state)
            cgrb_pkg::S_IDLE: s_axis_tready = 1'b1;
            cgrb_pkg::S_CLIP: ;
            cgrb_pkg::S_PLAN: load_rowless = geom.rowless && out_free;
            cgrb_pkg::S_ROWS: begin
                rd_en    = !iss_done && (!r_rd_vld || out_free);
                load_row = r_rd_vld && out_free;
            end
            default: ;
        endcase
    end

    assign s_accept   = s_axis_tvalid && s_axis_tready;
    assign draw_start = s_accept && (s_axis_tuser == cgrb_pkg::KIND_DRAW);
    assign wr_en      = s_accept && (s_axis_tuser == cgrb_pkg::KIND_LOAD);
    assign waddr      = {in_glyph_index, in_glyph_row};
    assign grow       = geom.yb + r_iss[4:0];
    assign raddr      = {geom.k, grow};

    // Glyph memory; loads are only taken while idle, so no read of a draw overlaps a write.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[waddr] <= in_row_bits;
        end
        if (rd_en) begin
            r_rdata <= r_mem[raddr];
        end
    end

    always_comb begin
        n_iss = r_iss;
        if (r_state == cgrb_pkg::S_PLAN) begin
            n_iss = 6'd0;
        end else if (rd_en) begin
            n_iss = iss_next;
        end
        n_rd_vld = rd_en ? 1'b1 : (out_free ? 1'b0 : r_rd_vld);
        n_m_valid = (load_row || load_rowless) ? 1'b1 : (m_axis_tready ? 1'b0 : r_m_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= cgrb_pkg::S_IDLE;
            r_iss     <= 6'd0;
            r_rd_vld  <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_iss     <= n_iss;
            r_rd_vld  <= n_rd_vld;
            r_m_valid <= n_m_valid;
        end
    end

    // Row index and end marker travel alongside the read in flight.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_row  <= geom.row0 + {6'd0, r_iss};
            r_rd_last <= (iss_next == geom.nl);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_row) begin
            r_m_rowv  <= 1'b1;
            r_m_last  <= r_rd_last;
            r_m_row   <= r_rd_row;
            r_m_col   <= geom.col;
            r_m_cnt   <= geom.nc;
            r_m_fg    <= (r_rdata >> geom.xb) & geom.cmask;
            r_m_color <= geom.color;
            r_m_opq   <= geom.opq;
            r_m_adv   <= geom.nc;
        end else if (load_rowless) begin
            r_m_rowv  <= 1'b0;
            r_m_last  <= 1'b1;
            r_m_row   <= 12'd0;
            r_m_col   <= 12'd0;
            r_m_cnt   <= 5'd0;
            r_m_fg    <= 16'd0;
            r_m_color <= 32'd0;
            r_m_opq   <= 1'b0;
            r_m_adv   <= geom.adv;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_rowv;
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tdata  = {5'd0, r_m_adv, r_m_opq, r_m_color, r_m_fg, r_m_cnt,
                            r_m_col, r_m_row};

    a_rd_only_in_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_state == cgrb_pkg::S_ROWS))
        else $error("glyph read in flight outside the row phase");

    a_iss_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cgrb_pkg::S_ROWS) |-> (r_iss <= geom.nl))
        else $error("more rows issued than visible");

    a_rowless_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
        else $error("rowless beat without end marker");

    a_geom_in_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        geom_vld |-> (r_state == cgrb_pkg::S_CLIP))
        else $error("clip result arrived outside the clip phase");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_en && rd_en))
        else $error("glyph memory written and read in the same cycle");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && !m_axis_tready) |-> !(load_row || load_rowless))
        else $error("output beat overwritten while stalled");

endmodule
